@@ sv/aes_sbox_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_sbox_pkg
// Constants and GF(2^8) helper functions for the AES forward S-box pipeline.
// ----------------------------------------------------------------------------
package aes_sbox_pkg;

   // field width of one byte
   localparam int BYTE_W = 8;

   // low byte of the reduction polynomial x^8+x^4+x^3+x+1
   localparam logic [BYTE_W-1:0] REDUCE_LOW = 8'h1B;

   // affine transform constant
   localparam logic [BYTE_W-1:0] AFFINE_CONST = 8'h63;

   // shift-and-add multiply in GF(2^8), eight narrow steps
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] y;
      acc = '0;
      y   = b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (a[k]) begin
            acc = acc ^ y;
         end
         if (y[BYTE_W-1]) begin
            y = {y[BYTE_W-2:0], 1'b0} ^ REDUCE_LOW;
         end else begin
            y = {y[BYTE_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

   // squaring is linear over GF(2); synthesis folds it to an XOR network
   function automatic logic [BYTE_W-1:0] gf_sq(input logic [BYTE_W-1:0] a);
      return gf_mul(a, a);
   endfunction

   // AES affine transform: v ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63
   function automatic logic [BYTE_W-1:0] affine(input logic [BYTE_W-1:0] v);
      return v
         ^ {v[6:0], v[7]}
         ^ {v[5:0], v[7:6]}
         ^ {v[4:0], v[7:5]}
         ^ {v[3:0], v[7:4]}
         ^ AFFINE_CONST;
   endfunction

endpackage

@@ sv/aes_sbox_if.sv @@
// ----------------------------------------------------------------------------
// aes_sbox_req_if / aes_sbox_rsp_if
// Valid/ready channels carrying the request byte and the substituted byte.
// ----------------------------------------------------------------------------
interface aes_sbox_req_if;
   logic                             valid;
   logic                             ready;
   logic [aes_sbox_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface aes_sbox_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [aes_sbox_pkg::BYTE_W-1:0]  sbox_byte;

   modport source (output valid, output sbox_byte, input ready);
   modport sink   (input valid, input sbox_byte, output ready);
endinterface

@@ sv/aes_sbox_byte_substitution_core.sv @@
// ----------------------------------------------------------------------------
// aes_sbox_byte_substitution_core
// AES forward S-box: GF(2^8) inverse as x^254 over a three-stage pipeline,
// followed by the affine transform.
// ----------------------------------------------------------------------------
//
//   channel    dir   payload           handshake
//   req_chan   in    in_byte[7:0]      valid/ready
//   rsp_chan   out   sbox_byte[7:0]    valid/ready
//
// Three register stages: the result passes through stages 1, 2 and 3 after the
// edge that accepts the request and is offered from the stage 3 register; one
// request is taken every cycle when the result side keeps ready high.
// Stage 1 forms x^2, x^3; stage 2 forms x^14, x^15; stage 3 forms
// x^254 = (x^15)^16 * x^14 and the affine transform into the output register.
// A synchronous reset clears the stage valid bits only.
// A stall holds each occupied stage; empty stages upstream of it still fill.
// ----------------------------------------------------------------------------
module aes_sbox_byte_substitution_core (
   input  logic                  clock,
   input  logic                  reset,
   aes_sbox_req_if.sink          req_chan,
   aes_sbox_rsp_if.source        rsp_chan
);

   localparam int W = aes_sbox_pkg::BYTE_W;

   // stage valid bits
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic          s1_valid_in, s2_valid_in, s3_valid_in;

   // stage payloads
   logic [W-1:0]  s1_x2_ff, s1_x3_ff;
   logic [W-1:0]  s2_x14_ff, s2_x15_ff;
   logic [W-1:0]  s3_sbox_ff;
   logic [W-1:0]  s1_x2_in, s1_x3_in;
   logic [W-1:0]  s2_x12, s2_x14_in, s2_x15_in;
   logic [W-1:0]  s3_x240, s3_inv, s3_sbox_in;

   // per-stage load enables
   logic          s1_load, s2_load, s3_load;

   // backpressure: a stage loads when it is empty or its content moves on
   assign s3_load = !s3_valid_ff || rsp_chan.ready;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;

   assign req_chan.ready = s1_load;

   assign s1_valid_in = s1_load ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff    : s2_valid_ff;
   assign s3_valid_in = s3_load ? s2_valid_ff    : s3_valid_ff;

   // stage 1 math: x^2 and x^3
   always_comb begin
      s1_x2_in = aes_sbox_pkg::gf_sq(req_chan.in_byte);
      s1_x3_in = aes_sbox_pkg::gf_mul(s1_x2_in, req_chan.in_byte);
   end

   // stage 2 math: x^12, then x^14 and x^15 in parallel
   always_comb begin
      s2_x12    = aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(s1_x3_ff));
      s2_x14_in = aes_sbox_pkg::gf_mul(s2_x12, s1_x2_ff);
      s2_x15_in = aes_sbox_pkg::gf_mul(s2_x12, s1_x3_ff);
   end

   // stage 3 math: x^240 by four squarings, inverse, affine
   always_comb begin
      s3_x240    = aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(
                   aes_sbox_pkg::gf_sq(aes_sbox_pkg::gf_sq(s2_x15_ff))));
      s3_inv     = aes_sbox_pkg::gf_mul(s3_x240, s2_x14_ff);
      s3_sbox_in = aes_sbox_pkg::affine(s3_inv);
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x2_ff <= s1_x2_in;
         s1_x3_ff <= s1_x3_in;
      end
      if (s2_load) begin
         s2_x14_ff <= s2_x14_in;
         s2_x15_ff <= s2_x15_in;
      end
      if (s3_load) begin
         s3_sbox_ff <= s3_sbox_in;
      end
   end

   assign rsp_chan.valid     = s3_valid_ff;
   assign rsp_chan.sbox_byte = s3_sbox_ff;

endmodule
